FILE: rtl/core/i2c_register_master_macros.svh
// Assertion macros used by the top level of the register-access I2C master RTL.
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define I2CRM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define I2CRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define I2CRM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2CRM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/i2crm_pkg.sv
// Types and constants of the register-access I2C master.
`default_nettype none

package i2crm_pkg;

   // Command codes.
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_BLOCK = 3'd3;
   localparam logic [2:0] OP_PROBE = 3'd4;

   // Bus item codes, the upper half of the phase.
   localparam logic [2:0] IT_START1 = 3'd0;
   localparam logic [2:0] IT_ADDRW  = 3'd1;
   localparam logic [2:0] IT_REG    = 3'd2;
   localparam logic [2:0] IT_VALUE  = 3'd3;
   localparam logic [2:0] IT_START2 = 3'd4;
   localparam logic [2:0] IT_ADDRR  = 3'd5;
   localparam logic [2:0] IT_RX     = 3'd6;
   localparam logic [2:0] IT_STOP   = 3'd7;

   localparam logic [5:0] PH_IDLE = 6'd63;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] BIT_ACKED     = 4'd8;
   localparam logic [3:0] BIT_NACKED    = 4'd9;

   localparam logic [15:0] DELAY_RESET = 16'd2;

   // One input transaction: a timing tick with pin samples and a command.
   typedef struct packed {
      logic       scl_in;
      logic       sda_in;
      logic [7:0] byte_count;
      logic [7:0] write_value;
      logic [7:0] reg_addr;
      logic [6:0] dev_addr;
      logic [2:0] op;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic       status;
      logic       done_res;
      logic       rx_last;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       busy_res;
      logic       sda_pull_low;
      logic       scl_pull_low;
   } rsp_type;

   // Sequencer state.
   typedef struct packed {
      logic [5:0]  phase;
      logic [15:0] tick_count;
      logic [3:0]  bit_index;
      logic [7:0]  shift_byte;
      logic [7:0]  bytes_left;
      logic [2:0]  op;
      logic [6:0]  dev_addr;
      logic [7:0]  reg_addr;
      logic [7:0]  write_value;
      logic        scl_drive;
      logic        sda_drive;
   } mst_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/i2crm_step.sv
// Next-state and result logic of the I2C master sequencer for one tick.
`default_nettype none

module i2crm_step
   import i2crm_pkg::*;
(
   input  mst_state_type cur_state,
   input  req_type       req,
   input  logic [15:0]   delay_ticks,
   output mst_state_type nxt_state,
   output rsp_type       rsp
);

   // Enter a segment: set the phase, restart the tick count, change the drives.
   function automatic mst_state_type enter_seg(input mst_state_type s,
                                               input logic [2:0] item,
                                               input logic [2:0] seg);
      mst_state_type r;
      r = s;
      r.phase = {item, seg};
      r.tick_count = 16'd1;
      case (item)
         IT_START1, IT_START2: begin
            case (seg)
               3'd0: r.sda_drive = 1'b0;
               3'd1: r.scl_drive = 1'b0;
               3'd2: r.sda_drive = 1'b1;
               default: r.scl_drive = 1'b1;
            endcase
         end
         IT_RX: begin
            case (seg)
               3'd0: begin
                  r.sda_drive = 1'b0;
                  r.scl_drive = 1'b0;
               end
               3'd3: r.scl_drive = 1'b1;
               3'd4: begin
                  r.sda_drive = (s.bytes_left > 8'd1);
                  r.scl_drive = 1'b0;
               end
               3'd5: begin
                  r.scl_drive = 1'b1;
                  r.sda_drive = 1'b0;
               end
               default: ;
            endcase
         end
         IT_STOP: begin
            case (seg)
               3'd0: r.sda_drive = 1'b1;
               3'd1: r.scl_drive = 1'b0;
               default: r.sda_drive = 1'b0;
            endcase
         end
         default: begin
            case (seg)
               3'd0: r.sda_drive = ~s.shift_byte[7];
               3'd1: r.scl_drive = 1'b0;
               3'd2: r.scl_drive = 1'b1;
               3'd3: begin
                  r.sda_drive = 1'b0;
                  r.scl_drive = 1'b0;
               end
               default: r.scl_drive = 1'b1;
            endcase
         end
      endcase
      return r;
   endfunction

   // Load a byte for transmission and enter its first bit.
   function automatic mst_state_type start_tx(input mst_state_type s,
                                              input logic [2:0] item,
                                              input logic [7:0] value);
      mst_state_type r;
      r = s;
      r.shift_byte = value;
      r.bit_index = '0;
      return enter_seg(r, item, 3'd0);
   endfunction

   // Return to idle at the end of a command.
   function automatic mst_state_type finish_cmd(input mst_state_type s);
      mst_state_type r;
      r = s;
      r.phase = PH_IDLE;
      r.tick_count = '0;
      r.bit_index = '0;
      return r;
   endfunction

   logic [2:0] item;
   logic [2:0] seg;
   logic [3:0] bit_inc;
   logic [7:0] left_dec;
   logic [7:0] shift_in;

   assign item     = cur_state.phase[5:3];
   assign seg      = cur_state.phase[2:0];
   assign bit_inc  = cur_state.bit_index + 4'd1;
   assign left_dec = cur_state.bytes_left - 8'd1;
   assign shift_in = {cur_state.shift_byte[6:0], req.sda_in};

   // Sequencer: command intake while idle, otherwise count ticks and advance.
   always_comb begin
      nxt_state = cur_state;
      rsp = '0;
      if (cur_state.phase == PH_IDLE) begin
         if (req.op inside {OP_READ, OP_WRITE, OP_BLOCK, OP_PROBE}) begin
            nxt_state.op = req.op;
            nxt_state.dev_addr = req.dev_addr;
            nxt_state.reg_addr = req.reg_addr;
            nxt_state.write_value = req.write_value;
            case (req.op)
               OP_READ:  nxt_state.bytes_left = 8'd1;
               OP_BLOCK: nxt_state.bytes_left = req.byte_count;
               default:  nxt_state.bytes_left = 8'd0;
            endcase
            nxt_state.bit_index = '0;
            nxt_state.shift_byte = '0;
            nxt_state = enter_seg(nxt_state, IT_START1, 3'd0);
         end
      end else if (item == IT_RX && seg == 3'd0) begin
         // The slave may stretch the clock before a received bit.
         if (req.scl_in) begin
            nxt_state = enter_seg(cur_state, IT_RX, 3'd1);
         end
      end else if (cur_state.tick_count < delay_ticks) begin
         nxt_state.tick_count = cur_state.tick_count + 16'd1;
      end else begin
         unique case (item)
            IT_START1, IT_START2: begin
               if (seg < 3'd3) begin
                  nxt_state = enter_seg(cur_state, item, seg + 3'd1);
               end else if (item == IT_START1) begin
                  nxt_state = start_tx(cur_state, IT_ADDRW, {cur_state.dev_addr, 1'b0});
               end else begin
                  nxt_state = start_tx(cur_state, IT_ADDRR, {cur_state.dev_addr, 1'b1});
               end
            end
            IT_RX: begin
               case (seg)
                  3'd1: begin
                     nxt_state.shift_byte = shift_in;
                     nxt_state = enter_seg(nxt_state, IT_RX, 3'd2);
                  end
                  3'd2: nxt_state = enter_seg(cur_state, IT_RX, 3'd3);
                  3'd3: begin
                     nxt_state.bit_index = bit_inc;
                     nxt_state = enter_seg(nxt_state, IT_RX,
                                           (bit_inc < BITS_PER_BYTE) ? 3'd0 : 3'd4);
                  end
                  3'd4: nxt_state = enter_seg(cur_state, IT_RX, 3'd5);
                  3'd5: begin
                     rsp.rx_valid = 1'b1;
                     rsp.rx_byte = cur_state.shift_byte;
                     rsp.rx_last = (cur_state.bytes_left == 8'd1);
                     nxt_state.bytes_left = left_dec;
                     if (left_dec == 8'd0) begin
                        nxt_state.bit_index = BIT_ACKED;
                        nxt_state = enter_seg(nxt_state, IT_STOP, 3'd0);
                     end else begin
                        nxt_state.shift_byte = '0;
                        nxt_state.bit_index = '0;
                        nxt_state = enter_seg(nxt_state, IT_RX, 3'd0);
                     end
                  end
                  default: nxt_state.phase = PH_IDLE;
               endcase
            end
            IT_STOP: begin
               if (seg < 3'd2) begin
                  nxt_state = enter_seg(cur_state, IT_STOP, seg + 3'd1);
               end else if (seg == 3'd2) begin
                  rsp.done_res = 1'b1;
                  rsp.status = (cur_state.bit_index == BIT_NACKED);
                  nxt_state = finish_cmd(cur_state);
               end else begin
                  nxt_state.phase = PH_IDLE;
               end
            end
            IT_ADDRW, IT_REG, IT_VALUE, IT_ADDRR: begin
               case (seg)
                  3'd0: nxt_state = enter_seg(cur_state, item, 3'd1);
                  3'd1: nxt_state = enter_seg(cur_state, item, 3'd2);
                  3'd2: begin
                     nxt_state.shift_byte = {cur_state.shift_byte[6:0], 1'b0};
                     nxt_state.bit_index = bit_inc;
                     nxt_state = enter_seg(nxt_state, item,
                                           (bit_inc < BITS_PER_BYTE) ? 3'd0 : 3'd3);
                  end
                  3'd3: begin
                     // Acknowledge slot: a high data line is a missing acknowledge.
                     nxt_state.bit_index = req.sda_in ? BIT_NACKED : BIT_ACKED;
                     nxt_state = enter_seg(nxt_state, item, 3'd4);
                  end
                  3'd4: begin
                     if (cur_state.bit_index == BIT_NACKED && cur_state.op != OP_PROBE) begin
                        rsp.done_res = 1'b1;
                        rsp.status = 1'b1;
                        nxt_state = finish_cmd(cur_state);
                     end else if (item == IT_ADDRW) begin
                        if (cur_state.op == OP_PROBE) begin
                           nxt_state = enter_seg(cur_state, IT_STOP, 3'd0);
                        end else begin
                           nxt_state = start_tx(cur_state, IT_REG, cur_state.reg_addr);
                        end
                     end else if (item == IT_REG) begin
                        if (cur_state.op == OP_WRITE) begin
                           nxt_state = start_tx(cur_state, IT_VALUE, cur_state.write_value);
                        end else begin
                           nxt_state = enter_seg(cur_state, IT_START2, 3'd0);
                        end
                     end else if (item == IT_VALUE) begin
                        nxt_state = enter_seg(cur_state, IT_STOP, 3'd0);
                     end else if (cur_state.bytes_left == 8'd0) begin
                        nxt_state = enter_seg(cur_state, IT_STOP, 3'd0);
                     end else begin
                        nxt_state.shift_byte = '0;
                        nxt_state.bit_index = '0;
                        nxt_state = enter_seg(nxt_state, IT_RX, 3'd0);
                     end
                  end
                  default: nxt_state.phase = PH_IDLE;
               endcase
            end
         endcase
      end
      rsp.scl_pull_low = nxt_state.scl_drive;
      rsp.sda_pull_low = nxt_state.sda_drive;
      rsp.busy_res = (nxt_state.phase != PH_IDLE);
   end

endmodule

`default_nettype wire

FILE: rtl/core/i2c_register_master.sv
// Top level of the register-access I2C master with its stream ports.
`default_nettype none

`include "i2c_register_master_macros.svh"

// Open-drain I2C master for single-byte register reads and writes, block reads
// and address probes. Every request transaction is one bus timing tick carrying
// the sampled SCL and SDA levels and, while the master is idle, a command; every
// request yields exactly one response transaction with the new pin drives and
// the byte, done and status flags of that tick. The sequencer state advances in
// a single combinational pass per tick and the response sits in one output
// register, so a tick is taken every clock cycle while the response side keeps
// up; the output register holding an untaken response is the only stall.
// Bit timing is set by csr_wr_data, counted in ticks per segment.
module i2c_register_master
   import i2crm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Tick stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] op, [9:3] dev_addr, [17:10] reg_addr, [25:18] write_value,
   // [33:26] byte_count, [34] sda_in, [35] scl_in, [39:36] zero
   input  logic [39:0] req_tdata,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] rx_valid,
   // [11:4] rx_byte, [12] done_res, [13] status, [15:14] zero
   output logic [15:0] rsp_tdata,
   // rx_last
   output logic        rsp_tlast,
   // Delay register write.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   req_type       req;
   mst_state_type state_ff;
   mst_state_type state_in;
   rsp_type       rsp_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic [15:0]   delay_ff;
   logic          accept;

   assign req = req_tdata[35:0];

   // A tick is taken unless an untaken result blocks the output register.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   i2crm_step u_step (
      .cur_state   (state_ff),
      .req         (req),
      .delay_ticks (delay_ff),
      .nxt_state   (state_in),
      .rsp         (rsp_in)
   );

   // Delay register.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // Sequencer state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, default: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.status, rsp_ff.done_res, rsp_ff.rx_byte,
                        rsp_ff.rx_valid, rsp_ff.busy_res, rsp_ff.sda_pull_low,
                        rsp_ff.scl_pull_low};
   assign rsp_tlast  = rsp_ff.rx_last;

   // A held result must never be overwritten by a new tick.
   `I2CRM_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)

   // A last-byte mark only comes with a received byte.
   `I2CRM_ASSERT_IMPLY(a_last_has_byte, clock, reset, rsp_valid_ff && rsp_ff.rx_last,
                       rsp_ff.rx_valid)

   // A failure status only comes with completion, and completion leaves the master idle.
   `I2CRM_ASSERT_IMPLY(a_status_done, clock, reset, rsp_valid_ff && rsp_ff.status,
                       rsp_ff.done_res && !rsp_ff.busy_res)

   // Sequencer state only moves on an accepted tick.
   `I2CRM_ASSERT_NEXT(a_state_hold, clock, reset, !accept, state_ff == $past(state_ff))

endmodule

`default_nettype wire
